// ===== rtl/ccbp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccbp_pkg
// Shared types and constants for the cyclic cubic Bezier path evaluator.
// ----------------------------------------------------------------------------
package ccbp_pkg;

	localparam int NSEG     = 8;
	localparam int SEG_W    = 3;
	localparam int FRAC     = 16;
	localparam int POS_W    = 32;
	localparam int TOT_W    = 35;
	localparam int W_W      = FRAC + 1;
	localparam int CNT_W    = 5;
	localparam int IN_W     = 264;
	localparam int OUT_W    = 104;

	localparam logic [W_W-1:0] ONE = W_W'(1) << FRAC;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_ACCEPT,
		OP_READ,
		OP_TOT_ADD,
		OP_MOD_INIT,
		OP_MOD_STEP,
		OP_WALK_CHECK,
		OP_DIV_INIT,
		OP_NXT_LATCH,
		OP_DIV_STEP,
		OP_MUL,
		OP_PT_MUL,
		OP_PT_ACC,
		OP_FIN_OK,
		OP_FIN_TZ,
		OP_FIN_DZ
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [SEG_W-1:0] addr;
		logic [CNT_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic total_zero;
		logic hit;
		logic dur_zero;
	} sts_t;

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [35:0] v);
		logic signed [35:0] hi;
		logic signed [35:0] lo;
		hi = 36'sh0_7FFF_FFFF;
		lo = -36'sh0_8000_0000;
		if (v > hi) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[POS_W-1:0];
		end
	endfunction

endpackage

// ===== rtl/ccbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccbp_ctrl
// Sequencer for loads and evaluations; issues one datapath command a cycle.
// ----------------------------------------------------------------------------
module ccbp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic                  action,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [3:0]            seg_count,
	output ccbp_pkg::cmd_t        cmd,
	input  ccbp_pkg::sts_t        sts
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_TOT_RD, ST_TOT_ADD, ST_MOD_INIT, ST_MOD_STEP, ST_WALK_RD,
		ST_WALK_CHK, ST_CUR_RD, ST_CUR_CHK, ST_NXT_RD, ST_NXT_LATCH, ST_DIV_STEP,
		ST_MUL, ST_PT_MUL, ST_PT_ACC, ST_OUT_OK, ST_OUT_TZ, ST_OUT_DZ
	} state_t;

	state_t                          state_q;
	logic [ccbp_pkg::CNT_W-1:0]      cnt_q;
	logic [ccbp_pkg::SEG_W-1:0]      cur_q;
	logic                            m_tvalid_q;
	logic [3:0]                      n;
	logic [3:0]                      cur_inc;
	logic [ccbp_pkg::SEG_W-1:0]      nxt;
	logic [ccbp_pkg::CNT_W-1:0]      last;
	logic                            slot_free;
	logic                            accept;
	logic                            out_set;

	always_comb begin
		if (seg_count == 4'd0) begin
			n = 4'd1;
		end else if (seg_count > 4'(ccbp_pkg::NSEG)) begin
			n = 4'(ccbp_pkg::NSEG);
		end else begin
			n = seg_count;
		end
	end

	assign last      = ccbp_pkg::CNT_W'(n) - ccbp_pkg::CNT_W'(1);
	assign cur_inc   = 4'(cur_q) + 4'd1;
	assign nxt       = (cur_inc == n) ? '0 : cur_inc[ccbp_pkg::SEG_W-1:0];
	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign out_set   = slot_free && ((state_q == ST_OUT_OK) || (state_q == ST_OUT_TZ) ||
		(state_q == ST_OUT_DZ));

	always_comb begin
		cmd.op   = ccbp_pkg::OP_IDLE;
		cmd.addr = cnt_q[ccbp_pkg::SEG_W-1:0];
		cmd.step = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) cmd.op = ccbp_pkg::OP_ACCEPT;
			end
			ST_TOT_RD, ST_WALK_RD: cmd.op = ccbp_pkg::OP_READ;
			ST_TOT_ADD:   cmd.op = ccbp_pkg::OP_TOT_ADD;
			ST_MOD_INIT: begin
				if (!sts.total_zero) cmd.op = ccbp_pkg::OP_MOD_INIT;
			end
			ST_MOD_STEP:  cmd.op = ccbp_pkg::OP_MOD_STEP;
			ST_WALK_CHK:  cmd.op = ccbp_pkg::OP_WALK_CHECK;
			ST_CUR_RD: begin
				cmd.op   = ccbp_pkg::OP_READ;
				cmd.addr = cur_q;
			end
			ST_CUR_CHK: begin
				if (!sts.dur_zero) cmd.op = ccbp_pkg::OP_DIV_INIT;
			end
			ST_NXT_RD: begin
				cmd.op   = ccbp_pkg::OP_READ;
				cmd.addr = nxt;
			end
			ST_NXT_LATCH: cmd.op = ccbp_pkg::OP_NXT_LATCH;
			ST_DIV_STEP:  cmd.op = ccbp_pkg::OP_DIV_STEP;
			ST_MUL:       cmd.op = ccbp_pkg::OP_MUL;
			ST_PT_MUL:    cmd.op = ccbp_pkg::OP_PT_MUL;
			ST_PT_ACC:    cmd.op = ccbp_pkg::OP_PT_ACC;
			ST_OUT_OK: begin
				cmd.addr = cur_q;
				if (slot_free) cmd.op = ccbp_pkg::OP_FIN_OK;
			end
			ST_OUT_TZ: begin
				if (slot_free) cmd.op = ccbp_pkg::OP_FIN_TZ;
			end
			ST_OUT_DZ: begin
				cmd.addr = cur_q;
				if (slot_free) cmd.op = ccbp_pkg::OP_FIN_DZ;
			end
			default: cmd.op = ccbp_pkg::OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			cur_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_set) m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && action) state_q <= ST_TOT_RD;
				end
				ST_TOT_RD: state_q <= ST_TOT_ADD;
				ST_TOT_ADD: begin
					if (cnt_q == last) begin
						cnt_q   <= '0;
						state_q <= ST_MOD_INIT;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_TOT_RD;
					end
				end
				ST_MOD_INIT: begin
					cnt_q   <= '0;
					state_q <= sts.total_zero ? ST_OUT_TZ : ST_MOD_STEP;
				end
				ST_MOD_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) state_q <= ST_WALK_RD;
				end
				ST_WALK_RD: state_q <= ST_WALK_CHK;
				ST_WALK_CHK: begin
					if (sts.hit || cnt_q == last) begin
						cur_q   <= cnt_q[ccbp_pkg::SEG_W-1:0];
						state_q <= ST_CUR_RD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_WALK_RD;
					end
				end
				ST_CUR_RD: state_q <= ST_CUR_CHK;
				ST_CUR_CHK: state_q <= sts.dur_zero ? ST_OUT_DZ : ST_NXT_RD;
				ST_NXT_RD: state_q <= ST_NXT_LATCH;
				ST_NXT_LATCH: begin
					cnt_q   <= '0;
					state_q <= ST_DIV_STEP;
				end
				ST_DIV_STEP: begin
					if (cnt_q == ccbp_pkg::CNT_W'(ccbp_pkg::FRAC)) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (cnt_q == ccbp_pkg::CNT_W'(5)) begin
						cnt_q   <= '0;
						state_q <= ST_PT_MUL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PT_MUL: state_q <= ST_PT_ACC;
				ST_PT_ACC: begin
					if (cnt_q == ccbp_pkg::CNT_W'(11)) begin
						state_q <= ST_OUT_OK;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_PT_MUL;
					end
				end
				ST_OUT_OK, ST_OUT_TZ, ST_OUT_DZ: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/ccbp_dp.sv =====
// ----------------------------------------------------------------------------
// ccbp_dp
// Segment stores, bit-serial modulo and divider, shared multiplier, output word.
// ----------------------------------------------------------------------------
module ccbp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ccbp_pkg::cmd_t                cmd,
	output ccbp_pkg::sts_t                sts,
	input  logic [ccbp_pkg::IN_W-1:0]     in_data,
	output logic [ccbp_pkg::OUT_W-1:0]    out_data,
	output logic                          out_err
);

	localparam int PW = ccbp_pkg::POS_W;
	localparam int WW = ccbp_pkg::W_W;
	localparam int TW = ccbp_pkg::TOT_W;

	logic [3*PW-1:0]    anchor_mem [ccbp_pkg::NSEG];
	logic [3*PW-1:0]    handle_mem [ccbp_pkg::NSEG];
	logic [PW-1:0]      dur_mem    [ccbp_pkg::NSEG];

	logic [3*PW-1:0]    rd_anchor_q, rd_handle_q;
	logic [PW-1:0]      rd_dur_q;
	logic [3*PW-1:0]    p0_q, p1_q, p2_q, p3_q;
	logic [TW-1:0]      total_q, span_q, start_q;
	logic [TW:0]        rem_q;
	logic [PW-1:0]      qry_q, dur_q, drem_q;
	logic               diff0_q;
	logic [WW-1:0]      quot_q, vv_q, uu_q;
	logic [WW-1:0]      w_q [4];
	logic signed [49:0] prod_q;
	logic signed [51:0] acc_q;
	logic signed [PW-1:0] res_q [3];
	logic [ccbp_pkg::OUT_W-1:0] out_data_q;
	logic               out_err_q;

	logic [ccbp_pkg::SEG_W-1:0] ld_seg;
	logic [3*PW-1:0]    ld_anchor, ld_tangent, ld_handle;
	logic [TW-1:0]      t_mod;
	logic [TW:0]        mod_trial;
	logic [TW:0]        span_end;
	logic [TW-1:0]      diff;
	logic [PW:0]        div_trial;
	logic [WW-1:0]      v;
	logic [18:0]        mul_a;
	logic [WW-1:0]      mul_b;
	logic [35:0]        mul_p;
	logic [1:0]         axis, term;
	logic signed [PW-1:0] pt;
	logic signed [51:0] acc_sum;
	logic signed [35:0] acc_shr;

	function automatic logic signed [31:0] pick(input logic [95:0] p, input logic [1:0] a);
		logic signed [31:0] r;
		unique case (a)
			2'd0:    r = p[31:0];
			2'd1:    r = p[63:32];
			default: r = p[95:64];
		endcase
		pick = r;
	endfunction

	assign ld_seg     = in_data[2:0];
	assign ld_anchor  = in_data[98:3];
	assign ld_tangent = in_data[194:99];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ld_handle[c*PW +: PW] = ccbp_pkg::sat32(
				36'(signed'(ld_anchor[c*PW +: PW])) + 36'(signed'(ld_tangent[c*PW +: PW])));
		end
	end

	assign t_mod     = rem_q[TW-1:0];
	assign mod_trial = {rem_q[TW-1:0], qry_q[PW-1]};
	assign span_end  = {1'b0, span_q} + (TW+1)'(rd_dur_q);
	assign diff      = (t_mod >= start_q) ? (t_mod - start_q) : '0;
	assign div_trial = {drem_q, (cmd.step == '0) ? diff0_q : 1'b0};
	assign v         = ccbp_pkg::ONE - quot_q;

	assign sts.total_zero = (total_q == '0);
	assign sts.hit        = (t_mod >= span_q) && ({1'b0, t_mod} <= span_end);
	assign sts.dur_zero   = (rd_dur_q == '0);

	always_comb begin
		mul_a = 19'(v);
		mul_b = v;
		unique case (cmd.step[2:0])
			3'd0: begin mul_a = 19'(v);                          mul_b = v;      end
			3'd1: begin mul_a = 19'(quot_q);                     mul_b = quot_q; end
			3'd2: begin mul_a = 19'(vv_q);                       mul_b = v;      end
			3'd3: begin mul_a = {vv_q, 1'b0} + 19'(vv_q);        mul_b = quot_q; end
			3'd4: begin mul_a = {uu_q, 1'b0} + 19'(uu_q);        mul_b = v;      end
			default: begin mul_a = 19'(uu_q);                    mul_b = quot_q; end
		endcase
	end
	assign mul_p = 36'(mul_a) * 36'(mul_b);

	assign axis = cmd.step[3:2];
	assign term = cmd.step[1:0];
	always_comb begin
		unique case (term)
			2'd0: pt = pick(p0_q, axis);
			2'd1: pt = pick(p1_q, axis);
			2'd2: pt = pick(p2_q, axis);
			default: pt = pick(p3_q, axis);
		endcase
	end
	assign acc_sum = ((term == 2'd0) ? 52'sd0 : acc_q) + 52'(prod_q);
	assign acc_shr = 36'(acc_sum >>> ccbp_pkg::FRAC);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ccbp_pkg::OP_ACCEPT: begin
				qry_q   <= in_data[258:227];
				total_q <= '0;
				if (!in_data[263] && (4'(ld_seg) < 4'(ccbp_pkg::NSEG))) begin
					anchor_mem[ld_seg] <= ld_anchor;
					handle_mem[ld_seg] <= ld_handle;
					dur_mem[ld_seg]    <= in_data[226:195];
				end
			end
			ccbp_pkg::OP_READ: begin
				rd_anchor_q <= anchor_mem[cmd.addr];
				rd_handle_q <= handle_mem[cmd.addr];
				rd_dur_q    <= dur_mem[cmd.addr];
			end
			ccbp_pkg::OP_TOT_ADD: total_q <= total_q + TW'(rd_dur_q);
			ccbp_pkg::OP_MOD_INIT: begin
				rem_q  <= '0;
				span_q <= '0;
			end
			ccbp_pkg::OP_MOD_STEP: begin
				qry_q <= {qry_q[PW-2:0], 1'b0};
				if (mod_trial >= {1'b0, total_q}) rem_q <= mod_trial - {1'b0, total_q};
				else rem_q <= mod_trial;
			end
			ccbp_pkg::OP_WALK_CHECK: begin
				span_q  <= span_end[TW-1:0];
				start_q <= sts.hit ? span_q : span_end[TW-1:0];
			end
			ccbp_pkg::OP_DIV_INIT: begin
				p0_q    <= rd_anchor_q;
				p1_q    <= rd_handle_q;
				dur_q   <= rd_dur_q;
				drem_q  <= {1'b0, diff[PW-1:1]};
				diff0_q <= diff[0];
				quot_q  <= '0;
			end
			ccbp_pkg::OP_NXT_LATCH: begin
				p2_q <= rd_handle_q;
				p3_q <= rd_anchor_q;
			end
			ccbp_pkg::OP_DIV_STEP: begin
				if (div_trial >= {1'b0, dur_q}) begin
					drem_q <= PW'(div_trial - {1'b0, dur_q});
					quot_q <= {quot_q[WW-2:0], 1'b1};
				end else begin
					drem_q <= div_trial[PW-1:0];
					quot_q <= {quot_q[WW-2:0], 1'b0};
				end
			end
			ccbp_pkg::OP_MUL: begin
				unique case (cmd.step[2:0])
					3'd0:    vv_q   <= mul_p[ccbp_pkg::FRAC +: WW];
					3'd1:    uu_q   <= mul_p[ccbp_pkg::FRAC +: WW];
					3'd2:    w_q[0] <= mul_p[ccbp_pkg::FRAC +: WW];
					3'd3:    w_q[1] <= mul_p[ccbp_pkg::FRAC +: WW];
					3'd4:    w_q[2] <= mul_p[ccbp_pkg::FRAC +: WW];
					default: w_q[3] <= mul_p[ccbp_pkg::FRAC +: WW];
				endcase
			end
			ccbp_pkg::OP_PT_MUL: prod_q <= 50'(pt) * 50'(signed'({1'b0, w_q[term]}));
			ccbp_pkg::OP_PT_ACC: begin
				acc_q <= acc_sum;
				if (term == 2'd3) res_q[axis] <= ccbp_pkg::sat32(acc_shr);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_data_q <= '0;
			out_err_q  <= 1'b0;
		end else begin
			unique case (cmd.op)
				ccbp_pkg::OP_FIN_OK: begin
					out_data_q <= {5'b0, cmd.addr, res_q[2], res_q[1], res_q[0]};
					out_err_q  <= 1'b0;
				end
				ccbp_pkg::OP_FIN_TZ: begin
					out_data_q <= '0;
					out_err_q  <= 1'b1;
				end
				ccbp_pkg::OP_FIN_DZ: begin
					out_data_q <= {5'b0, cmd.addr, rd_anchor_q};
					out_err_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign out_data = out_data_q;
	assign out_err  = out_err_q;

endmodule

// ===== rtl/cyclic_cubic_bezier_path.sv =====
// ----------------------------------------------------------------------------
// cyclic_cubic_bezier_path
// Closed 3D path of cubic Bezier segments evaluated at a time.
// ----------------------------------------------------------------------------
// A load word is written into the segment stores when it is taken and
// gives no result. For an evaluate word the time modulo total duration
// runs one bit a cycle, the fraction divider one bit a cycle, the segment
// walk and the duration sum read the segment store in a read state before
// each check or add, one shared multiplier forms the six weight products
// and a second multiplier the twelve point products. One evaluation is in
// flight at a time; the next word is taken while a result waits on m_tready.
// ----------------------------------------------------------------------------
module cyclic_cubic_bezier_path (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// seg_index[2:0], anchor_x/y/z[98:3], tangent_x/y/z[194:99],
	// seg_duration[226:195], query_time[258:227], zero fill
	input  logic [263:0] s_tdata,
	// action[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64], seg_chosen[98:96], zero fill
	output logic [103:0] m_tdata,
	// eval_error[0]
	output logic [0:0]   m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [3:0]           seg_count_q;
	ccbp_pkg::cmd_t       cmd;
	ccbp_pkg::sts_t       sts;
	logic [ccbp_pkg::IN_W-1:0] in_data;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {28'd0, seg_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= 4'd1;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			seg_count_q <= pwdata[3:0];
		end
	end

	assign in_data = {s_tuser[0], s_tdata[262:0]};

	ccbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.action    (s_tuser[0]),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.seg_count (seg_count_q),
		.cmd       (cmd),
		.sts       (sts)
	);

	ccbp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.out_data (m_tdata),
		.out_err  (m_tuser[0])
	);

endmodule

// ===== tb/sv/ccbp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ccbp_checker
// Watches the input, output and register channels of the Bezier path
// evaluator, keeps its own copy of the segment stores and the segment count,
// predicts each evaluation result and compares the outgoing words in order.
// ----------------------------------------------------------------------------
module ccbp_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [ccbp_pkg::IN_W-1:0]  s_tdata,
	input  logic [0:0]                 s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [ccbp_pkg::OUT_W-1:0] m_tdata,
	input  logic [0:0]                 m_tuser,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	output int                         errors,
	output int                         pending
);

	localparam logic       ACT_LOAD      = 1'b0;
	localparam logic [2:0] REG_SEG_COUNT = 3'd0;

	typedef struct {
		logic [31:0]                px;
		logic [31:0]                py;
		logic [31:0]                pz;
		logic [ccbp_pkg::SEG_W-1:0] seg;
		logic                       err;
	} path_point_t;

	logic signed [31:0] anchor_mem [ccbp_pkg::NSEG][3];
	logic signed [31:0] handle_mem [ccbp_pkg::NSEG][3];
	logic [31:0]        span_mem   [ccbp_pkg::NSEG];
	logic [3:0]         seg_count;
	path_point_t        point_q [$];
	int                 miss_cnt;

	function automatic logic signed [31:0] clamp_pos(input longint v);
		if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
		if (v < -longint'(64'h8000_0000)) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic path_point_t locate_point(input logic [31:0] qt);
		path_point_t r;
		longint unsigned total, t, span, d, one, u, v, uu, vv;
		longint w [4];
		longint acc;
		int n, cur, nxt;
		bit hit;
		n = (seg_count == 0) ? 1 :
			((seg_count > ccbp_pkg::NSEG) ? ccbp_pkg::NSEG : int'(seg_count));
		total = 0;
		for (int i = 0; i < n; i++) total += span_mem[i];
		r.px = 0; r.py = 0; r.pz = 0; r.seg = 0; r.err = 1'b1;
		if (total == 0) return r;
		t = longint'(qt) % total;
		cur = n - 1;
		span = 0;
		hit = 0;
		for (int i = 0; i < n && !hit; i++) begin
			if (t >= span && t <= span + span_mem[i]) begin
				cur = i;
				hit = 1;
			end else begin
				span += span_mem[i];
			end
		end
		nxt = (cur + 1) % n;
		d = span_mem[cur];
		r.seg = cur[ccbp_pkg::SEG_W-1:0];
		if (d == 0) begin
			r.px = anchor_mem[cur][0];
			r.py = anchor_mem[cur][1];
			r.pz = anchor_mem[cur][2];
			return r;
		end
		one = 64'd1 << ccbp_pkg::FRAC;
		u = (t >= span) ? ((t - span) << ccbp_pkg::FRAC) / d : 0;
		if (u > one) u = one;
		v = one - u;
		vv = (v * v) >> ccbp_pkg::FRAC;
		uu = (u * u) >> ccbp_pkg::FRAC;
		w[0] = (vv * v) >> ccbp_pkg::FRAC;
		w[1] = (3 * vv * u) >> ccbp_pkg::FRAC;
		w[2] = (3 * uu * v) >> ccbp_pkg::FRAC;
		w[3] = (uu * u) >> ccbp_pkg::FRAC;
		for (int c = 0; c < 3; c++) begin
			acc = longint'(anchor_mem[cur][c]) * w[0] + longint'(handle_mem[cur][c]) * w[1]
				+ longint'(handle_mem[nxt][c]) * w[2] + longint'(anchor_mem[nxt][c]) * w[3];
			acc = acc >>> ccbp_pkg::FRAC;
			case (c)
				0: r.px = clamp_pos(acc);
				1: r.py = clamp_pos(acc);
				default: r.pz = clamp_pos(acc);
			endcase
		end
		r.err = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		path_point_t e;
		logic signed [31:0] a, tg;
		logic [2:0] s;
		if (!arst_n) begin
			seg_count <= 4'd1;
			errors <= 0;
			pending <= 0;
			miss_cnt = 0;
			point_q.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_SEG_COUNT)
				seg_count <= pwdata[3:0];
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == ACT_LOAD) begin
					s = s_tdata[2:0];
					for (int c = 0; c < 3; c++) begin
						a = s_tdata[3 + 32*c +: 32];
						tg = s_tdata[99 + 32*c +: 32];
						anchor_mem[s][c] <= a;
						handle_mem[s][c] <= clamp_pos(longint'(a) + longint'(tg));
					end
					span_mem[s] <= s_tdata[226:195];
				end else begin
					point_q.push_back(locate_point(s_tdata[258:227]));
				end
			end
			if (m_tvalid && m_tready) begin
				if (point_q.size() == 0) begin
					miss_cnt++;
					if (miss_cnt <= 10)
						$display("%0t: result word with nothing expected: %h/%b",
							$realtime, m_tdata, m_tuser);
				end else begin
					e = point_q.pop_front();
					if (m_tdata[31:0] !== e.px || m_tdata[63:32] !== e.py ||
							m_tdata[95:64] !== e.pz || m_tdata[98:96] !== e.seg ||
							m_tuser[0] !== e.err) begin
						miss_cnt++;
						if (miss_cnt <= 10)
							$display("%0t: mismatch exp x=%h y=%h z=%h seg=%0d err=%b got x=%h y=%h z=%h seg=%0d err=%b",
								$realtime, e.px, e.py, e.pz, e.seg, e.err, m_tdata[31:0],
								m_tdata[63:32], m_tdata[95:64], m_tdata[98:96], m_tuser[0]);
					end
				end
			end
			errors <= miss_cnt;
			pending <= point_q.size();
		end
	end

endmodule

// ===== tb/sv/cyclic_cubic_bezier_path_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cyclic_cubic_bezier_path_tb
// Drives segment loads, evaluations and segment-count writes into the path
// evaluator under random stalls on both sides in most phases, and reports the
// verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module cyclic_cubic_bezier_path_tb;

	localparam logic       ACT_LOAD      = 1'b0;
	localparam logic       ACT_EVAL      = 1'b1;
	localparam logic [2:0] REG_SEG_COUNT = 3'd0;
	localparam logic [2:0] REG_NONE      = 3'd4;
	localparam int         STALL_LIMIT   = 4000;
	localparam int         DRAIN_CYCLES  = 130;

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       s_tvalid = 0;
	logic                       s_tready;
	logic [ccbp_pkg::IN_W-1:0]  s_tdata = '0;
	logic [0:0]                 s_tuser = '0;
	logic                       m_tvalid;
	logic                       m_tready = 0;
	logic [ccbp_pkg::OUT_W-1:0] m_tdata;
	logic [0:0]                 m_tuser;
	logic                       psel = 0;
	logic                       penable = 0;
	logic                       pwrite = 0;
	logic [2:0]                 paddr = '0;
	logic [31:0]                pwdata = '0;
	logic [31:0]                prdata;
	logic                       pready;
	int                         errors, pending;
	int                         send_idle = 15, recv_idle = 61, phase_no = -1;
	int                         quiet = 0;
	int                         dur_mode = 0;

	cyclic_cubic_bezier_path dut (.*);

	ccbp_checker chk (.*);

	initial forever #6 clk = ~clk;

	function automatic logic [ccbp_pkg::IN_W-1:0] seg_word(input logic [2:0] idx,
			input logic [31:0] ax, ay, az, tx, ty, tz, dur, qt);
		return {5'b0, qt, dur, tz, ty, tx, az, ay, ax, idx};
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(3) - 2;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_dur();
		if ($urandom_range(9) == 0) return 0;
		case (dur_mode)
			0: return $urandom_range(4);
			1: return $urandom_range(8) << 15;
			2: return $urandom;
			default: return $urandom_range(32'h0004_0000);
		endcase
	endfunction

	task automatic push(input logic act, input logic [ccbp_pkg::IN_W-1:0] d);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic load_seg(input logic [2:0] idx, input logic [31:0] ax, ay, az,
			tx, ty, tz, dur);
		push(ACT_LOAD, seg_word(idx, ax, ay, az, tx, ty, tz, dur, $urandom));
	endtask

	task automatic eval_at(input logic [31:0] qt);
		push(ACT_EVAL, seg_word(3'($urandom), $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, qt));
	endtask

	task automatic reg_write(input logic [2:0] a, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver: random backpressure, one long hold-off in phase two
	initial begin
		bit held;
		held = 0;
		@(posedge clk iff arst_n);
		forever begin
			@(posedge clk);
			if (!held && phase_no == 2) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				held = 1;
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog on accepted words and register accesses
	initial begin
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int counts [12] = '{3, 8, 1, 0, 15, 5, 2, 8, 7, 4, 6, 9};
		int n_items;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_write(REG_NONE, 32'hFFFF_FFFF);
		reg_write(REG_SEG_COUNT, 32'd8);
		load_seg(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF, 32'h0001_0000);
		load_seg(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0000_0001, 32'h0002_0000);
		load_seg(2, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0, 0);
		load_seg(3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'h8000);
		for (int i = 4; i < ccbp_pkg::NSEG; i++)
			load_seg(3'(i), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
				pick_coord(), pick_coord(), 32'h0001_0000);
		eval_at(0);
		eval_at(32'h0001_0000);
		eval_at(32'h0000_8000);
		eval_at(32'h0003_0000);
		eval_at(32'h7FFF_FFFF);
		eval_at(32'hFFFF_FFFF);
		settle();

		// zero total duration
		reg_write(REG_SEG_COUNT, 32'd1);
		load_seg(0, 32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 0, 0, 0, 0);
		eval_at(32'h1234_5678);
		settle();

		// zero-length segment picked at time zero
		reg_write(REG_SEG_COUNT, 32'd2);
		load_seg(1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		eval_at(0);
		eval_at(5);
		settle();

		for (int p = 0; p < 12; p++) begin
			if (p < 4) begin
				send_idle = 15; recv_idle = 61;
			end else if (p < 8) begin
				send_idle = 61; recv_idle = 15;
			end else begin
				send_idle = 0; recv_idle = 0;
			end
			dur_mode = p % 4;
			reg_write(REG_SEG_COUNT, {28'($urandom_range(32'hFFF_FFFF)), 4'(counts[p])});
			phase_no = p;
			n_items = 125;
			for (int k = 0; k < n_items; k++) begin
				if ($urandom_range(9) < 3)
					load_seg(3'($urandom), pick_coord(), pick_coord(), pick_coord(),
						pick_coord(), pick_coord(), pick_coord(), pick_dur());
				else if ($urandom_range(1))
					eval_at($urandom_range(64));
				else
					eval_at($urandom);
			end
			settle();
		end

		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ccbp_pkg.sv
rtl/ccbp_ctrl.sv
rtl/ccbp_dp.sv
rtl/cyclic_cubic_bezier_path.sv
tb/sv/ccbp_checker.sv
tb/sv/cyclic_cubic_bezier_path_tb.sv
